### sv/ccdpm_pkg.sv
package ccdpm_pkg;

    // Field and register widths
    localparam int unsigned MAX_PHASES   = 8;
    localparam int unsigned STEP_W       = 4;
    localparam int unsigned PHASE_W      = 3;
    localparam int unsigned COUNT_W      = 4;
    localparam int unsigned OFFSET_W     = 3;
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned CFG_DATA_W   = 4;
    localparam int unsigned REM_W        = 5;
    localparam int unsigned DIVISOR_W    = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_AWAY  = 1'd1;

    // Reset values of the configuration registers
    localparam logic [COUNT_W-1:0] PHASE_COUNT_RST = 4'd3;
    localparam logic               FORCE_AWAY_RST  = 1'b1;

    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [PHASE_W-1:0]  phase_t;
    typedef logic [REM_W-1:0]    rem_t;

    // One restoring step of the fold modulo: subtract the shifted divisor if it fits
    function automatic rem_t mod_step(input rem_t r, input logic [DIVISOR_W-1:0] d);
        logic [DIVISOR_W-1:0] r_wide;
        logic [DIVISOR_W-1:0] diff;
        r_wide = {{(DIVISOR_W-REM_W){1'b0}}, r};
        diff   = r_wide - d;
        return (r_wide >= d) ? diff[REM_W-1:0] : r;
    endfunction

endpackage

### sv/ccdpm_if.sv
interface ccdpm_item_if;
    logic                              valid;
    logic                              ready;
    logic [ccdpm_pkg::STEP_W-1:0]      step_index;
    logic [ccdpm_pkg::PHASE_W-1:0]     phase_index;

    modport source (output valid, output step_index, output phase_index, input ready);
    modport sink   (input valid, input step_index, input phase_index, output ready);
endinterface

interface ccdpm_result_if;
    logic                                valid;
    logic                                ready;
    logic                                phase_high;
    logic                                capture_valid;
    logic                                capture_offset;
    logic                                release_split;
    logic signed [ccdpm_pkg::OFFSET_W-1:0] release_offset_a;
    logic signed [ccdpm_pkg::OFFSET_W-1:0] release_offset_b;

    modport source (output valid, output phase_high, output capture_valid,
                    output capture_offset, output release_split,
                    output release_offset_a, output release_offset_b, input ready);
    modport sink   (input valid, input phase_high, input capture_valid,
                    input capture_offset, input release_split,
                    input release_offset_a, input release_offset_b, output ready);
endinterface

interface ccdpm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ccdpm_pkg::CFG_IDX_W-1:0]     index;
    logic [ccdpm_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/ccd_clock_phase_capture_release_map.sv
// An accepted request reaches the result channel through the stage registers named below.
// Throughput: one request per cycle; four register stages (add, two pairs of
// restoring modulo steps with the fold, release map) each hold one request.
// A stalled result holds the pipe; bubbles collapse, so stages keep filling.
// Reset: asynchronous, active low; clears all valid bits, sets phase_count to 3
// and force_away_from_readout to 1. No clearing pass.
module ccd_clock_phase_capture_release_map (
    input  logic                   clk,
    input  logic                   rst_n,
    ccdpm_cfg_if.sink              cfg,
    ccdpm_item_if.sink             item,
    ccdpm_result_if.source         result
);

    // Configuration registers
    ccdpm_pkg::count_t phase_count_reg;
    logic              force_away_reg;
    ccdpm_pkg::count_t n_eff;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_count_reg <= ccdpm_pkg::PHASE_COUNT_RST;
            force_away_reg  <= ccdpm_pkg::FORCE_AWAY_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ccdpm_pkg::REG_PHASE_COUNT: phase_count_reg <= cfg.data;
                ccdpm_pkg::REG_FORCE_AWAY:  force_away_reg  <= cfg.data[0];
                default:                    ;
            endcase
        end
    end

    // Clamp the phase count to 1..MAX_PHASES
    always_comb
    begin
        if (phase_count_reg == '0)
            n_eff = ccdpm_pkg::count_t'(1);
        else if (phase_count_reg > ccdpm_pkg::count_t'(ccdpm_pkg::MAX_PHASES))
            n_eff = ccdpm_pkg::count_t'(ccdpm_pkg::MAX_PHASES);
        else
            n_eff = phase_count_reg;
    end

    // Pipeline valid bits and stage load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ld1, ld2, ld3, ld4;

    assign ld4        = !v4_reg || result.ready;
    assign ld3        = !v3_reg || ld4;
    assign ld2        = !v2_reg || ld3;
    assign ld1        = !v1_reg || ld2;
    assign item.ready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= item.valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: form step + N
    ccdpm_pkg::rem_t    x1_reg, x1_next;
    ccdpm_pkg::phase_t  ph1_reg;
    logic [ccdpm_pkg::DIVISOR_W-1:0] m_wide;

    assign x1_next = ccdpm_pkg::rem_t'(item.step_index) + ccdpm_pkg::rem_t'(n_eff);
    assign m_wide  = {{(ccdpm_pkg::DIVISOR_W-ccdpm_pkg::COUNT_W){1'b0}}, n_eff} << 1;

    always_ff @(posedge clk)
    begin
        if (ld1 && item.valid)
        begin
            x1_reg  <= x1_next;
            ph1_reg <= item.phase_index;
        end
    end

    // Stage 2: subtract 8*2N and 4*2N where they fit
    ccdpm_pkg::rem_t    r2_reg, r2_next;
    ccdpm_pkg::phase_t  ph2_reg;

    assign r2_next = ccdpm_pkg::mod_step(ccdpm_pkg::mod_step(x1_reg, m_wide << 3), m_wide << 2);

    always_ff @(posedge clk)
    begin
        if (ld2 && v1_reg)
        begin
            r2_reg  <= r2_next;
            ph2_reg <= ph1_reg;
        end
    end

    // Stage 3: finish the modulo, fold around N, find the high phase
    ccdpm_pkg::rem_t    r3;
    ccdpm_pkg::rem_t    n_rem;
    ccdpm_pkg::rem_t    loop3;
    ccdpm_pkg::phase_t  high3_reg, high3_next;
    logic               shifted3_reg, shifted3_next;
    ccdpm_pkg::phase_t  ph3_reg;

    always_comb
    begin
        r3    = ccdpm_pkg::mod_step(ccdpm_pkg::mod_step(r2_reg, m_wide << 1), m_wide);
        n_rem = ccdpm_pkg::rem_t'(n_eff);
        loop3 = (r3 >= n_rem) ? (r3 - n_rem) : (n_rem - r3);
        shifted3_next = (loop3 == n_rem);
        high3_next    = shifted3_next ? '0 : loop3[ccdpm_pkg::PHASE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld3 && v2_reg)
        begin
            high3_reg    <= high3_next;
            shifted3_reg <= shifted3_next;
            ph3_reg      <= ph2_reg;
        end
    end

    // Stage 4: capture and release map
    logic                               present;
    logic                               is_high;
    logic                               split;
    logic                               above_high;
    logic [ccdpm_pkg::COUNT_W-1:0]      half;
    logic [ccdpm_pkg::COUNT_W-1:0]      sp_sum;
    logic [ccdpm_pkg::COUNT_W-1:0]      split_phase;
    logic signed [ccdpm_pkg::COUNT_W-1:0] d;
    logic signed [ccdpm_pkg::COUNT_W-1:0] half_s;
    logic [1:0]                         bump;
    logic signed [ccdpm_pkg::OFFSET_W-1:0] ra_base, rb_base, ra, rb;

    logic                                  phase_high_reg, phase_high_next;
    logic                                  capture_offset_reg, capture_offset_next;
    logic                                  release_split_reg, release_split_next;
    logic signed [ccdpm_pkg::OFFSET_W-1:0] release_a_reg, release_a_next;
    logic signed [ccdpm_pkg::OFFSET_W-1:0] release_b_reg, release_b_next;

    always_comb
    begin
        present     = (ccdpm_pkg::count_t'(ph3_reg) < n_eff);
        is_high     = (ph3_reg == high3_reg);
        above_high  = (ph3_reg > high3_reg);
        half        = n_eff >> 1;
        sp_sum      = ccdpm_pkg::count_t'(high3_reg) + half;
        split_phase = (sp_sum >= n_eff) ? (sp_sum - n_eff) : sp_sum;
        split       = !n_eff[0] && (ccdpm_pkg::count_t'(ph3_reg) == split_phase);
        d           = $signed(ccdpm_pkg::count_t'(ph3_reg)) - $signed(ccdpm_pkg::count_t'(high3_reg));
        half_s      = $signed(half);

        // Base destination before the shifts
        rb_base = '0;
        if (split)
        begin
            if (ph3_reg < high3_reg)
            begin
                ra_base = 3'sd0;
                rb_base = 3'sd1;
            end
            else
            begin
                ra_base = -3'sd1;
                rb_base = 3'sd0;
            end
        end
        else if (is_high)
            ra_base = shifted3_reg ? 3'sd1 : 3'sd0;
        else if (d < -half_s)
            ra_base = 3'sd1;
        else if (d > half_s)
            ra_base = -3'sd1;
        else
            ra_base = 3'sd0;

        // Move one pixel for the wrapped low phases and away from readout
        bump = {1'b0, !is_high && shifted3_reg} + {1'b0, force_away_reg && above_high};
        ra   = ra_base + $signed({1'b0, bump});
        rb   = split ? (rb_base + $signed({1'b0, bump})) : 3'sd0;

        if (present)
        begin
            phase_high_next     = is_high;
            capture_offset_next = is_high && shifted3_reg;
            release_split_next  = split;
            release_a_next      = ra;
            release_b_next      = rb;
        end
        else
        begin
            phase_high_next     = 1'b0;
            capture_offset_next = 1'b0;
            release_split_next  = 1'b0;
            release_a_next      = '0;
            release_b_next      = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld4 && v3_reg)
        begin
            phase_high_reg     <= phase_high_next;
            capture_offset_reg <= capture_offset_next;
            release_split_reg  <= release_split_next;
            release_a_reg      <= release_a_next;
            release_b_reg      <= release_b_next;
        end
    end

    assign result.valid            = v4_reg;
    assign result.phase_high       = phase_high_reg;
    assign result.capture_valid    = phase_high_reg;
    assign result.capture_offset   = capture_offset_reg;
    assign result.release_split    = release_split_reg;
    assign result.release_offset_a = release_a_reg;
    assign result.release_offset_b = release_b_reg;

`ifndef NO_ASSERTIONS
    // An empty output stage never blocks new requests
    assert property (@(posedge clk) disable iff (!rst_n) !result.valid |-> item.ready)
        else $error("request refused while output stage is empty");

    // Capture from the next pixel only happens on a high phase
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.capture_offset |-> result.phase_high)
        else $error("capture offset set on a low phase");

    // Second destination is zero unless the release is split
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.release_split |-> result.release_offset_b == '0)
        else $error("second release destination without split");

    // A split phase is never the high phase
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.release_split |-> !result.phase_high)
        else $error("split release on the high phase");
`endif

endmodule

### test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // One expected or observed map entry, in result-field order
    typedef struct packed {
        logic                           phase_high;
        logic                           capture_valid;
        logic                           capture_offset;
        logic                           release_split;
        logic [ccdpm_pkg::OFFSET_W-1:0] release_offset_a;
        logic [ccdpm_pkg::OFFSET_W-1:0] release_offset_b;
    } pixel_map_t;

    // One directed probe: register setting, request, and optionally a typed-in map
    typedef struct packed {
        ccdpm_pkg::count_t            count;
        logic                         away;
        logic [ccdpm_pkg::STEP_W-1:0] step;
        ccdpm_pkg::phase_t            phase;
        logic                         typed;
        pixel_map_t                   want;
    } probe_t;

    localparam pixel_map_t NO_MAP      = '0;
    localparam int         NUM_PROBES  = 25;
    localparam int         NUM_RANDOM  = 2000;
    localparam int         BLOCK_LEN   = 250;
    localparam int         DRAIN_SLACK = 6;
    localparam int         HOLD_AT     = 600;
    localparam int         HOLD_LEN    = 80;

    localparam probe_t PROBES [NUM_PROBES] = '{
        '{4'd3,  1'b1, 4'd0,  3'd0, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 3'd0, 3'd0}},
        '{4'd3,  1'b1, 4'd3,  3'd0, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 3'd1, 3'd0}},
        '{4'd3,  1'b1, 4'd3,  3'd2, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 3'd1, 3'd0}},
        '{4'd3,  1'b1, 4'd15, 3'd7, 1'b1, NO_MAP},
        '{4'd3,  1'b1, 4'd5,  3'd1, 1'b0, NO_MAP},
        '{4'd3,  1'b0, 4'd3,  3'd2, 1'b0, NO_MAP},
        '{4'd3,  1'b0, 4'd1,  3'd2, 1'b0, NO_MAP},
        '{4'd4,  1'b1, 4'd0,  3'd2, 1'b0, NO_MAP},
        '{4'd4,  1'b1, 4'd2,  3'd0, 1'b0, NO_MAP},
        '{4'd4,  1'b1, 4'd7,  3'd1, 1'b0, NO_MAP},
        '{4'd4,  1'b0, 4'd6,  3'd3, 1'b0, NO_MAP},
        '{4'd0,  1'b1, 4'd0,  3'd0, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 3'd0, 3'd0}},
        '{4'd0,  1'b1, 4'd1,  3'd0, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 3'd1, 3'd0}},
        '{4'd0,  1'b0, 4'd14, 3'd1, 1'b1, NO_MAP},
        '{4'd1,  1'b1, 4'd15, 3'd0, 1'b0, NO_MAP},
        '{4'd8,  1'b1, 4'd0,  3'd7, 1'b0, NO_MAP},
        '{4'd8,  1'b1, 4'd8,  3'd4, 1'b0, NO_MAP},
        '{4'd8,  1'b0, 4'd15, 3'd7, 1'b0, NO_MAP},
        '{4'd8,  1'b0, 4'd12, 3'd3, 1'b0, NO_MAP},
        '{4'd15, 1'b0, 4'd0,  3'd0, 1'b0, NO_MAP},
        '{4'd15, 1'b1, 4'd9,  3'd7, 1'b0, NO_MAP},
        '{4'd6,  1'b1, 4'd11, 3'd5, 1'b0, NO_MAP},
        '{4'd2,  1'b1, 4'd3,  3'd1, 1'b0, NO_MAP},
        '{4'd7,  1'b1, 4'd13, 3'd6, 1'b0, NO_MAP},
        '{4'd5,  1'b0, 4'd15, 3'd4, 1'b0, NO_MAP}
    };

    logic clk;
    logic rst_n;

    ccdpm_cfg_if    cfg_ch ();
    ccdpm_item_if   item_ch ();
    ccdpm_result_if res_ch ();

    ccd_clock_phase_capture_release_map dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (res_ch)
    );

    // Register shadow, expected maps, and run bookkeeping
    ccdpm_pkg::count_t cfg_count;
    logic              cfg_away;
    pixel_map_t        pending_maps [$];
    int                mismatch_count;
    int                accepted_requests;
    int                burst_left;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the pipe locks up
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int phases_in_use(input ccdpm_pkg::count_t count);
        int n;
        n = int'(count);
        if (n < 1)
            n = 1;
        if (n > int'(ccdpm_pkg::MAX_PHASES))
            n = int'(ccdpm_pkg::MAX_PHASES);
        return n;
    endfunction

    // Capture/release map for one step and phase under the current register shadow
    function automatic pixel_map_t predict_map(input logic [ccdpm_pkg::STEP_W-1:0] step,
                                               input ccdpm_pkg::phase_t phase);
        int         n;
        int         fold;
        int         hi;
        int         split_ph;
        int         cap;
        int         ra;
        int         rb;
        int         d;
        int         ph;
        bit         on_high;
        bit         split;
        bit         past_end;
        pixel_map_t m;
        n  = phases_in_use(cfg_count);
        ph = int'(phase);
        m  = NO_MAP;
        if (ph >= n)
            return m;

        // fold the step so a pumping sequence runs forward and back
        fold = (int'(step) + n) % (2 * n) - n;
        if (fold < 0)
            fold = -fold;
        hi       = fold % n;
        split_ph = (n % 2 == 0) ? (hi + n / 2) % n : -1;
        on_high  = (ph == hi);
        past_end = (fold > n - 1);
        cap      = (on_high && past_end) ? 1 : 0;
        split    = (ph == split_ph);
        ra       = 0;
        rb       = 0;

        // release goes to the nearest high phase, or half to each of two
        if (split)
        begin
            if (ph < hi)
            begin
                ra = 0;
                rb = 1;
            end
            else
            begin
                ra = -1;
                rb = 0;
            end
        end
        else if (on_high)
            ra = cap;
        else
        begin
            d = ph - hi;
            if (d < -(n / 2))
                ra = 1;
            else if (d > n / 2)
                ra = -1;
            else
                ra = 0;
        end

        if (!on_high && past_end)
        begin
            ra += 1;
            rb += 1;
        end

        // push phases past the high one away from readout
        if (cfg_away && ph > hi)
        begin
            if (on_high)
                cap += 1;
            ra += 1;
            rb += 1;
        end

        if (!split)
            rb = 0;

        m.phase_high       = on_high;
        m.capture_valid    = on_high;
        m.capture_offset   = on_high ? cap[0] : 1'b0;
        m.release_split    = split;
        m.release_offset_a = ra[ccdpm_pkg::OFFSET_W-1:0];
        m.release_offset_b = rb[ccdpm_pkg::OFFSET_W-1:0];
        return m;
    endfunction

    // Offer one request, hold it until accepted, then queue its expected map
    task automatic offer_request(input logic [ccdpm_pkg::STEP_W-1:0] step,
                                 input ccdpm_pkg::phase_t phase,
                                 input pixel_map_t want);
        item_ch.valid       <= 1'b1;
        item_ch.step_index  <= step;
        item_ch.phase_index <= phase;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        pending_maps.push_back(want);
        accepted_requests++;
    endtask

    // Keep the burst going or drop valid for a random gap
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8)
                                                 : $urandom_range(10, 60);
        gap = $urandom_range(0, 5);
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drain the pipe, then write one register
    task automatic set_register(input logic [ccdpm_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ccdpm_pkg::CFG_DATA_W-1:0] value);
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_maps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == ccdpm_pkg::REG_PHASE_COUNT)
            cfg_count = value;
        else
            cfg_away = value[0];
    endtask

    task automatic report_mismatch(input string what, input pixel_map_t want,
                                   input pixel_map_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t: %s: expected high=%0b cap=%0b/%0b split=%0b a=%0d b=%0d,",
                      " got high=%0b cap=%0b/%0b split=%0b a=%0d b=%0d"},
                     $realtime, what,
                     want.phase_high, want.capture_valid, want.capture_offset,
                     want.release_split, $signed(want.release_offset_a),
                     $signed(want.release_offset_b),
                     got.phase_high, got.capture_valid, got.capture_offset,
                     got.release_split, $signed(got.release_offset_a),
                     $signed(got.release_offset_b));
    endtask

    // Result receiver: stall patterns plus one long hold-off to back up the pipe
    initial
    begin : result_drain
        int         hold_left;
        bit         held_once;
        int         mode;
        int         mode_left;
        logic [7:0] mask;
        hold_left = 0;
        held_once = 0;
        mode      = 0;
        mode_left = 0;
        mask      = 8'hff;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (!held_once && accepted_requests >= HOLD_AT)
            begin
                held_once = 1;
                hold_left = HOLD_LEN - 1;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 40);
                    mask      = 8'($urandom);
                end
                mode_left--;
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        res_ch.ready <= mask[0];
                        mask = {mask[0], mask[7:1]};
                    end
                endcase
            end
        end
    end

    // Check every accepted result against the oldest expected map
    always @(posedge clk)
    begin : result_check
        pixel_map_t got;
        pixel_map_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.phase_high       = res_ch.phase_high;
            got.capture_valid    = res_ch.capture_valid;
            got.capture_offset   = res_ch.capture_offset;
            got.release_split    = res_ch.release_split;
            got.release_offset_a = res_ch.release_offset_a;
            got.release_offset_b = res_ch.release_offset_b;
            if (pending_maps.size() == 0)
                report_mismatch("result with nothing expected", NO_MAP, got);
            else
            begin
                want = pending_maps.pop_front();
                if (got.phase_high !== want.phase_high
                    || got.capture_valid !== want.capture_valid
                    || got.capture_offset !== want.capture_offset
                    || got.release_split !== want.release_split
                    || got.release_offset_a !== want.release_offset_a
                    || got.release_offset_b !== want.release_offset_b)
                    report_mismatch("map mismatch", want, got);
            end
        end
    end

    // Main stimulus: reset, directed probes, then random blocks per setting
    initial
    begin : stimulus
        logic [ccdpm_pkg::STEP_W-1:0] step;
        ccdpm_pkg::phase_t            phase;
        pixel_map_t                   want;
        int                           n;
        ccdpm_pkg::count_t            count;
        mismatch_count    = 0;
        accepted_requests = 0;
        burst_left        = 0;
        cfg_count         = ccdpm_pkg::PHASE_COUNT_RST;
        cfg_away          = ccdpm_pkg::FORCE_AWAY_RST;
        rst_n               <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.step_index  <= '0;
        item_ch.phase_index <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= ccdpm_pkg::REG_PHASE_COUNT;
        cfg_ch.data         <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed probes
        for (int i = 0; i < NUM_PROBES; i++)
        begin
            if (PROBES[i].count != cfg_count)
                set_register(ccdpm_pkg::REG_PHASE_COUNT, PROBES[i].count);
            if (PROBES[i].away != cfg_away)
                set_register(ccdpm_pkg::REG_FORCE_AWAY, {3'($urandom), PROBES[i].away});
            want = PROBES[i].typed ? PROBES[i].want
                                   : predict_map(PROBES[i].step, PROBES[i].phase);
            offer_request(PROBES[i].step, PROBES[i].phase, want);
            pace_sender();
        end

        // random blocks, each under a fresh register setting
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i % BLOCK_LEN == 0)
            begin
                case ($urandom_range(0, 6))
                    0: count = 4'd0;
                    1: count = 4'd15;
                    2: count = 4'd8;
                    3: count = 4'd1;
                    default: count = 4'($urandom_range(1, 8));
                endcase
                set_register(ccdpm_pkg::REG_PHASE_COUNT, count);
                set_register(ccdpm_pkg::REG_FORCE_AWAY, 4'($urandom));
            end
            n = phases_in_use(cfg_count);
            if ($urandom_range(0, 3) != 0)
            begin
                step  = 4'($urandom_range(0, 2 * n - 1));
                phase = 3'($urandom_range(0, n - 1));
            end
            else
            begin
                step  = 4'($urandom_range(0, 15));
                phase = 3'($urandom_range(0, 7));
            end
            offer_request(step, phase, predict_map(step, phase));
            pace_sender();
        end

        // wait out the pipe
        item_ch.valid <= 1'b0;
        while (pending_maps.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
